@@ sv/varint_tlv_stream_parser_unit_assert.svh @@
// ---------------------------------------------------------------------------
// varint tlv stream parser assertion macros
// shared property forms for the concurrent checks of the parser
// ---------------------------------------------------------------------------
`ifndef VARINT_TLV_STREAM_PARSER_UNIT_ASSERT_SVH
`define VARINT_TLV_STREAM_PARSER_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is active
`define VTSP_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is active
`define VTSP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/vtsp_pkg.sv @@
// ---------------------------------------------------------------------------
// vtsp_pkg
// types and codes shared by the varint tlv stream parser modules
// ---------------------------------------------------------------------------
package vtsp_pkg;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_VALUE  = 2'd1,
    KIND_DONE   = 2'd2,
    KIND_ERROR  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_TYPE_CUT   = 3'd1,
    ERR_LENGTH_CUT = 3'd2,
    ERR_VALUE_CUT  = 3'd3,
    ERR_OVERFLOW   = 3'd4,
    ERR_NONCANON   = 3'd5
  } err_e;

  typedef enum logic [1:0] {
    PH_TYPE   = 2'd0,
    PH_LENGTH = 2'd1,
    PH_VALUE  = 2'd2
  } phase_e;

  // last byte index of a 64-bit varint
  localparam logic [3:0] VarintLastIdx = 4'd9;

  // one queue word: an optional header or value result, then an optional status
  typedef struct packed {
    logic        has_main;
    kind_e       main_kind;
    logic [63:0] elem_type;
    logic [63:0] value_length;
    logic [7:0]  value_byte;
    logic        has_status;
    err_e        status_err;
  } entry_t;

endpackage

@@ sv/varint_tlv_stream_parser_unit.sv @@
// ---------------------------------------------------------------------------
// varint_tlv_stream_parser_unit
// streaming parser of type-length-value elements with leb128 varint fields
// ---------------------------------------------------------------------------
//  channel | direction | handshake              | words
//  in      | input     | in_valid_i/in_ready_o   | one buffer byte, end flag
//  out     | output    | out_valid_o/out_ready_i | header, value byte or status
//
// one input word per cycle while the queue is not full; the front parser updates its state in that cycle
// a byte that gives a result and closes the buffer yields two output words
// the queue of FifoDepth words lets the input run on while the output stalls
// in_ready_o drops only when the queue is full
// reset returns the parser to the start of a buffer and empties the queue
// ---------------------------------------------------------------------------
`include "varint_tlv_stream_parser_unit_assert.svh"

module varint_tlv_stream_parser_unit import vtsp_pkg::*; #(
  parameter int unsigned FifoDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_buffer_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [63:0] element_type_o,
  output logic [63:0] value_length_o,
  output logic [7:0]  value_byte_o,
  output logic [2:0]  error_code_o,
  output logic        last_of_buffer_o
);

  logic   accept;
  logic   push;
  logic   pop;
  logic   full;
  logic   empty;
  entry_t wr_entry;
  entry_t head;
  logic   status_shape_ok;
  logic   data_shape_ok;

  assign in_ready_o = !full;
  assign accept     = in_valid_i && in_ready_o;

  vtsp_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .data_byte_i     (data_byte_i),
    .end_of_buffer_i (end_of_buffer_i),
    .push_o          (push),
    .entry_o         (wr_entry)
  );

  vtsp_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (wr_entry),
    .pop_i   (pop),
    .rdata_o (head),
    .full_o  (full),
    .empty_o (empty)
  );

  vtsp_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_i           (head),
    .head_valid_i     (!empty),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .kind_o           (kind_o),
    .element_type_o   (element_type_o),
    .value_length_o   (value_length_o),
    .value_byte_o     (value_byte_o),
    .error_code_o     (error_code_o),
    .last_of_buffer_o (last_of_buffer_o)
  );

  // shape of the word on the output, split by the last flag
  assign status_shape_ok = !last_of_buffer_o ||
                           (kind_o == KIND_DONE && error_code_o == ERR_NONE) ||
                           (kind_o == KIND_ERROR && error_code_o != ERR_NONE);
  assign data_shape_ok   = last_of_buffer_o ||
                           ((kind_o == KIND_HEADER || kind_o == KIND_VALUE) &&
                            error_code_o == ERR_NONE);

  `VTSP_ASSERT_NOW(a_push_not_full, clk_i, rst_ni, push, !full, "push into full queue")
  `VTSP_ASSERT_NOW(a_pop_not_empty, clk_i, rst_ni, pop, !empty, "pop from empty queue")
  `VTSP_ASSERT_NOW(a_last_is_status, clk_i, rst_ni, out_valid_o, status_shape_ok, "bad status")
  `VTSP_ASSERT_NOW(a_status_is_last, clk_i, rst_ni, out_valid_o, data_shape_ok, "bad data word")

endmodule

@@ sv/vtsp_front.sv @@
// ---------------------------------------------------------------------------
// vtsp_front
// byte-level parser: decodes the varints, tracks element phase and builds
// one queue word per byte that yields a result
// ---------------------------------------------------------------------------
module vtsp_front import vtsp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_buffer_i,
  output logic        push_o,
  output entry_t      entry_o
);

  phase_e      phase_q, phase_d;
  logic [63:0] accum_q, accum_d;
  logic [3:0]  shift_q, shift_d;
  logic [63:0] type_q, type_d;
  logic [63:0] len_q, len_d;
  logic [63:0] left_q, left_d;
  logic        failed_q, failed_d;
  err_e        code_q, code_d;

  logic [5:0]  offs;
  logic        ovf;
  logic        noncanon;
  logic        vi_done;
  logic [63:0] accum_new;
  err_e        status_err;

  // varint byte decode
  always_comb begin
    offs      = 6'({2'b00, shift_q} * 6'd7);
    ovf       = (shift_q >= VarintLastIdx) && (data_byte_i[7:1] != 7'd0);
    noncanon  = (data_byte_i == 8'd0) && (shift_q != 4'd0);
    vi_done   = !data_byte_i[7];
    accum_new = accum_q | ({57'd0, data_byte_i[6:0]} << offs);
  end

  // next state
  always_comb begin
    phase_d    = phase_q;
    accum_d    = accum_q;
    shift_d    = shift_q;
    type_d     = type_q;
    len_d      = len_q;
    left_d     = left_q;
    failed_d   = failed_q;
    code_d     = code_q;
    status_err = ERR_NONE;
    if (accept_i) begin
      if (!failed_q) begin
        case (phase_q)
          PH_VALUE: begin
            left_d = left_q - 64'd1;
            if (left_q == 64'd1) begin
              phase_d = PH_TYPE;
            end
          end
          default: begin
            if (ovf) begin
              failed_d = 1'b1;
              code_d   = ERR_OVERFLOW;
            end else if (noncanon) begin
              failed_d = 1'b1;
              code_d   = ERR_NONCANON;
            end else if (vi_done) begin
              if (phase_q == PH_LENGTH) begin
                len_d   = accum_new;
                left_d  = accum_new;
                phase_d = (accum_new == 64'd0) ? PH_TYPE : PH_VALUE;
              end else begin
                type_d  = accum_new;
                phase_d = PH_LENGTH;
              end
              accum_d = 64'd0;
              shift_d = 4'd0;
            end else begin
              accum_d = accum_new;
              shift_d = shift_q + 4'd1;
            end
          end
        endcase
      end
      if (end_of_buffer_i) begin
        if (failed_d) begin
          status_err = code_d;
        end else if (phase_d == PH_LENGTH) begin
          status_err = ERR_LENGTH_CUT;
        end else if (phase_d == PH_VALUE) begin
          status_err = ERR_VALUE_CUT;
        end else if (shift_d != 4'd0) begin
          status_err = ERR_TYPE_CUT;
        end
        // buffer closed: back to the reset state
        phase_d  = PH_TYPE;
        accum_d  = 64'd0;
        shift_d  = 4'd0;
        type_d   = 64'd0;
        len_d    = 64'd0;
        left_d   = 64'd0;
        failed_d = 1'b0;
        code_d   = ERR_NONE;
      end
    end
  end

  // queue word
  always_comb begin
    entry_o              = '0;
    entry_o.has_main     = accept_i && !failed_q &&
                           ((phase_q == PH_VALUE) ||
                            ((phase_q == PH_LENGTH) && !ovf && !noncanon && vi_done));
    entry_o.main_kind    = (phase_q == PH_VALUE) ? KIND_VALUE : KIND_HEADER;
    entry_o.elem_type    = type_q;
    entry_o.value_length = (phase_q == PH_VALUE) ? len_q : accum_new;
    entry_o.value_byte   = (phase_q == PH_VALUE) ? data_byte_i : 8'd0;
    entry_o.has_status   = accept_i && end_of_buffer_i;
    entry_o.status_err   = status_err;
    push_o               = entry_o.has_main || entry_o.has_status;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_TYPE;
      accum_q  <= 64'd0;
      shift_q  <= 4'd0;
      type_q   <= 64'd0;
      len_q    <= 64'd0;
      left_q   <= 64'd0;
      failed_q <= 1'b0;
      code_q   <= ERR_NONE;
    end else begin
      phase_q  <= phase_d;
      accum_q  <= accum_d;
      shift_q  <= shift_d;
      type_q   <= type_d;
      len_q    <= len_d;
      left_q   <= left_d;
      failed_q <= failed_d;
      code_q   <= code_d;
    end
  end

endmodule

@@ sv/vtsp_fifo.sv @@
// ---------------------------------------------------------------------------
// vtsp_fifo
// short queue of parser words between front and back
// ---------------------------------------------------------------------------
module vtsp_fifo import vtsp_pkg::*; #(
  parameter int unsigned Depth = 4
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t wdata_i,
  input  logic   pop_i,
  output entry_t rdata_o,
  output logic   full_o,
  output logic   empty_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);
  localparam logic [AW-1:0] LastPtr = AW'(Depth - 1);
  localparam logic [CW-1:0] FullCnt = CW'(Depth);

  entry_t          mem_q [Depth];
  logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]   cnt_q;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + AW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + AW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

endmodule

@@ sv/vtsp_back.sv @@
// ---------------------------------------------------------------------------
// vtsp_back
// expands queue words into result words and holds them in the output register
// ---------------------------------------------------------------------------
module vtsp_back import vtsp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  entry_t      head_i,
  input  logic        head_valid_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [63:0] element_type_o,
  output logic [63:0] value_length_o,
  output logic [7:0]  value_byte_o,
  output logic [2:0]  error_code_o,
  output logic        last_of_buffer_o
);

  logic        valid_q, valid_d;
  logic        main_done_q, main_done_d;
  kind_e       kind_q, kind_d;
  logic [63:0] type_q, type_d;
  logic [63:0] len_q, len_d;
  logic [7:0]  vb_q, vb_d;
  err_e        err_q, err_d;
  logic        last_q, last_d;
  logic        load;

  always_comb begin
    load        = !valid_q || out_ready_i;
    pop_o       = 1'b0;
    valid_d     = valid_q;
    main_done_d = main_done_q;
    kind_d      = kind_q;
    type_d      = type_q;
    len_d       = len_q;
    vb_d        = vb_q;
    err_d       = err_q;
    last_d      = last_q;
    if (load) begin
      valid_d = head_valid_i;
      if (head_valid_i) begin
        if (head_i.has_main && !main_done_q) begin
          kind_d = head_i.main_kind;
          type_d = head_i.elem_type;
          len_d  = head_i.value_length;
          vb_d   = head_i.value_byte;
          err_d  = ERR_NONE;
          last_d = 1'b0;
          // keep the word when a status still follows
          if (head_i.has_status) begin
            main_done_d = 1'b1;
          end else begin
            pop_o = 1'b1;
          end
        end else begin
          kind_d      = (head_i.status_err == ERR_NONE) ? KIND_DONE : KIND_ERROR;
          type_d      = 64'd0;
          len_d       = 64'd0;
          vb_d        = 8'd0;
          err_d       = head_i.status_err;
          last_d      = 1'b1;
          main_done_d = 1'b0;
          pop_o       = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= 1'b0;
      main_done_q <= 1'b0;
    end else begin
      valid_q     <= valid_d;
      main_done_q <= main_done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    type_q <= type_d;
    len_q  <= len_d;
    vb_q   <= vb_d;
    err_q  <= err_d;
    last_q <= last_d;
  end

  assign out_valid_o      = valid_q;
  assign kind_o           = kind_q;
  assign element_type_o   = type_q;
  assign value_length_o   = len_q;
  assign value_byte_o     = vb_q;
  assign error_code_o     = err_q;
  assign last_of_buffer_o = last_q;

endmodule
